>>> rtl/core/wsfd_pkg.sv
// Shared types, constants and helpers for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsfd_pkg;

  // Width of the payload length counter, wide enough for the full 64-bit extended length.
  localparam int LEN_W = 64;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HDR0    = 2'd0,
    PH_LEN     = 2'd1,
    PH_EXT     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  // Opcodes of interest.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Seven-bit length codes that introduce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Number of extended length bytes for each form.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Frame kind codes.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // One result handed from the parser to the output register.
  typedef struct packed {
    logic       message_end;
    logic       frame_end;
    logic [1:0] frame_kind;
    logic       has_payload;
    logic [7:0] payload_byte;
  } result_t;

  // Map an opcode to the frame kind tag.
  function automatic logic [1:0] kind_of(input logic [3:0] op);
    logic [1:0] k;
    case (op)
      OP_CONT, OP_TEXT: k = KIND_DATA;
      OP_PING:          k = KIND_PING;
      OP_CLOSE:         k = KIND_CLOSE;
      default:          k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/wsfd_in_reg.sv
// Input register stage holding one received byte.
`timescale 1ns / 1ps

module wsfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] rx_byte
);

  // Room for a new request when empty or when the held byte is consumed now.
  assign s_axis_tready = !byte_valid || take;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      byte_valid <= 1'b1;
    end else if (take) begin
      byte_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rx_byte <= s_axis_tdata;
    end
  end

endmodule

>>> rtl/core/wsfd_parser.sv
// Frame header parser and payload counter.
`timescale 1ns / 1ps

module wsfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        rx_byte,
  input  logic              space,
  output logic              take,
  output logic              res_valid,
  output wsfd_pkg::result_t res
);

  wsfd_pkg::phase_t              phase, phase_next;
  logic [3:0]                    frame_opcode, frame_opcode_next;
  logic                          final_flag, final_flag_next;
  logic [3:0]                    ext_left, ext_left_next;
  logic [wsfd_pkg::LEN_W-1:0]    remaining, remaining_next;
  logic                          emit;
  logic                          last;
  logic [6:0]                    len7;
  logic [1:0]                    kind;

  assign len7 = rx_byte[6:0];
  assign kind = wsfd_pkg::kind_of(frame_opcode);

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_next        = phase;
    frame_opcode_next = frame_opcode;
    final_flag_next   = final_flag;
    ext_left_next     = ext_left;
    remaining_next    = remaining;
    emit              = 1'b0;
    last              = 1'b0;
    case (phase)
      wsfd_pkg::PH_HDR0: begin
        frame_opcode_next = rx_byte[3:0];
        final_flag_next   = rx_byte[7];
        phase_next        = wsfd_pkg::PH_LEN;
      end
      wsfd_pkg::PH_LEN: begin
        remaining_next = '0;
        if (len7 == wsfd_pkg::LEN_EXT16) begin
          ext_left_next = wsfd_pkg::EXT16_BYTES;
          phase_next    = wsfd_pkg::PH_EXT;
        end else if (len7 == wsfd_pkg::LEN_EXT64) begin
          ext_left_next = wsfd_pkg::EXT64_BYTES;
          phase_next    = wsfd_pkg::PH_EXT;
        end else begin
          ext_left_next  = '0;
          remaining_next = {{(wsfd_pkg::LEN_W-7){1'b0}}, len7};
          if (len7 == 7'd0) begin
            emit       = 1'b1;
            last       = 1'b1;
            phase_next = wsfd_pkg::PH_HDR0;
          end else begin
            phase_next = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_EXT: begin
        // Big-endian accumulation; high bits shift out.
        remaining_next = {remaining[wsfd_pkg::LEN_W-9:0], rx_byte};
        ext_left_next  = ext_left - 4'd1;
        if (ext_left_next == 4'd0) begin
          if (remaining_next == '0) begin
            emit       = 1'b1;
            last       = 1'b1;
            phase_next = wsfd_pkg::PH_HDR0;
          end else begin
            phase_next = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      default: begin
        remaining_next = remaining - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
        last           = (remaining_next == '0);
        emit           = 1'b1;
        if (last) begin
          phase_next = wsfd_pkg::PH_HDR0;
        end
      end
    endcase
  end

  // A byte is consumed unless it has a result and the output is full.
  assign take      = byte_valid && (!emit || space);
  assign res_valid = take && emit;

  // Result fields; the byte only carries data in the payload phase.
  always_comb begin
    res.has_payload  = (phase == wsfd_pkg::PH_PAYLOAD);
    res.payload_byte = res.has_payload ? rx_byte : 8'd0;
    res.frame_kind   = kind;
    res.frame_end    = last;
    res.message_end  = last && (kind == wsfd_pkg::KIND_DATA) && final_flag;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wsfd_pkg::PH_HDR0;
      frame_opcode <= '0;
      final_flag   <= 1'b0;
      ext_left     <= '0;
      remaining    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      frame_opcode <= frame_opcode_next;
      final_flag   <= final_flag_next;
      ext_left     <= ext_left_next;
      remaining    <= remaining_next;
    end
  end

endmodule

>>> rtl/core/wsfd_out_reg.sv
// Result register driving the master-side stream.
`timescale 1ns / 1ps

module wsfd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  wsfd_pkg::result_t res,
  output logic              space,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [7:0] payload_byte
  output logic              m_axis_tlast,  // frame_end
  output logic [3:0]        m_axis_tuser   // [0] has_payload, [2:1] frame_kind, [3] message_end
);

  // Free when empty or when the held request leaves this cycle.
  assign space = !m_axis_tvalid || m_axis_tready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= res.payload_byte;
      m_axis_tlast <= res.frame_end;
      m_axis_tuser <= {res.message_end, res.frame_kind, res.has_payload};
    end
  end

endmodule

>>> rtl/core/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer.
// A byte passes the input register and the parser to the result register.
// One byte per cycle unless m_axis stalls; the parser state updates once per byte.
// Header bytes produce no result, except the last header byte of an empty frame.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to expecting the first header byte.
`timescale 1ns / 1ps

module websocket_frame_deframer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,   // frame_end
  output logic [3:0] m_axis_tuser    // [0] has_payload, [2:1] frame_kind, [3] message_end
);

  logic              take;
  logic              byte_valid;
  logic [7:0]        rx_byte;
  logic              space;
  logic              res_valid;
  wsfd_pkg::result_t res;

  // Input register.
  wsfd_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take          (take),
    .byte_valid    (byte_valid),
    .rx_byte       (rx_byte)
  );

  // Header parser and payload counter.
  wsfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte),
    .space      (space),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register.
  wsfd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .space         (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> rtl/core/wsfd_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
`timescale 1ns / 1ps

module wsfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [3:0] m_axis_tuser
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A result without data is always the end of an empty frame.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("empty result that is not a zeroed frame end");

  // Message end only on the end of a data frame.
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |->
      m_axis_tlast && (m_axis_tuser[2:1] == wsfd_pkg::KIND_DATA))
    else $error("message end outside a data frame end");

  // A stalled request holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output request changed");

  // A waiting input request holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("waiting input request changed");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> verif/websocket_frame_deframer_checker.sv
// Checker for the WebSocket frame deframer: tracks the parser, predicts results and compares.
`timescale 1ns / 1ps

module websocket_frame_deframer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  input  logic       m_axis_tlast,   // frame_end
  input  logic [3:0] m_axis_tuser,   // [0] has_payload, [2:1] frame_kind, [3] message_end
  output int         fails,
  output int         outstanding
);

  // Our own view of the parser.
  wsfd_pkg::phase_t           rx_phase;
  logic [3:0]                 cur_opcode;
  logic                       cur_fin;
  logic [3:0]                 ext_bytes_left;
  logic [wsfd_pkg::LEN_W-1:0] bytes_remaining;

  // Results predicted but not yet seen on the output, oldest first.
  wsfd_pkg::result_t awaited_results[$];

  initial begin
    fails       = 0;
    outstanding = 0;
  end

  // Tag that the consumer sees for a given opcode.
  function automatic logic [1:0] frame_kind_for(input logic [3:0] op);
    if (op == wsfd_pkg::OP_CONT || op == wsfd_pkg::OP_TEXT) return wsfd_pkg::KIND_DATA;
    if (op == wsfd_pkg::OP_PING) return wsfd_pkg::KIND_PING;
    if (op == wsfd_pkg::OP_CLOSE) return wsfd_pkg::KIND_CLOSE;
    return wsfd_pkg::KIND_OTHER;
  endfunction

  // Queue one expected result for the current frame.
  task automatic expect_output(input logic [7:0] data, input logic has, input logic last);
    wsfd_pkg::result_t r;
    r.payload_byte = data;
    r.has_payload  = has;
    r.frame_kind   = frame_kind_for(cur_opcode);
    r.frame_end    = last;
    r.message_end  = last && (r.frame_kind == wsfd_pkg::KIND_DATA) && cur_fin;
    awaited_results.push_back(r);
  endtask

  // Advance the parser by one received byte.
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [6:0] len7;
    len7 = b[6:0];
    case (rx_phase)
      wsfd_pkg::PH_HDR0: begin
        // Reserved bits are ignored; only FIN and the opcode matter.
        cur_opcode = b[3:0];
        cur_fin    = b[7];
        rx_phase   = wsfd_pkg::PH_LEN;
      end
      wsfd_pkg::PH_LEN: begin
        // The mask bit is ignored, so a mask key is simply counted as payload.
        bytes_remaining = '0;
        if (len7 == wsfd_pkg::LEN_EXT16) begin
          ext_bytes_left = wsfd_pkg::EXT16_BYTES;
          rx_phase       = wsfd_pkg::PH_EXT;
        end else if (len7 == wsfd_pkg::LEN_EXT64) begin
          ext_bytes_left = wsfd_pkg::EXT64_BYTES;
          rx_phase       = wsfd_pkg::PH_EXT;
        end else begin
          ext_bytes_left  = '0;
          bytes_remaining = wsfd_pkg::LEN_W'(len7);
          if (len7 == '0) begin
            rx_phase = wsfd_pkg::PH_HDR0;
            expect_output(8'h00, 1'b0, 1'b1);
          end else begin
            rx_phase = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_EXT: begin
        // Big-endian accumulation; the counter holds all eight extended length bytes.
        bytes_remaining = {bytes_remaining[wsfd_pkg::LEN_W-9:0], b};
        ext_bytes_left  = ext_bytes_left - 4'd1;
        if (ext_bytes_left == '0) begin
          if (bytes_remaining == '0) begin
            rx_phase = wsfd_pkg::PH_HDR0;
            expect_output(8'h00, 1'b0, 1'b1);
          end else begin
            rx_phase = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      default: begin
        bytes_remaining = bytes_remaining - wsfd_pkg::LEN_W'(1);
        if (bytes_remaining == '0) rx_phase = wsfd_pkg::PH_HDR0;
        expect_output(b, 1'b1, bytes_remaining == '0);
      end
    endcase
  endtask

  // One line per mismatch.
  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: %s got %0h, expected %0h", $time, field, got, want);
    fails++;
  endtask

  // Compare an accepted output request with the oldest expectation.
  task automatic check_output();
    wsfd_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing awaited, payload_byte", m_axis_tdata, 8'h00);
      return;
    end
    want = awaited_results.pop_front();
    if (m_axis_tdata !== want.payload_byte)
      report_mismatch("payload_byte", m_axis_tdata, want.payload_byte);
    if (m_axis_tuser[0] !== want.has_payload)
      report_mismatch("has_payload", 8'(m_axis_tuser[0]), 8'(want.has_payload));
    if (m_axis_tuser[2:1] !== want.frame_kind)
      report_mismatch("frame_kind", 8'(m_axis_tuser[2:1]), 8'(want.frame_kind));
    if (m_axis_tlast !== want.frame_end)
      report_mismatch("frame_end", 8'(m_axis_tlast), 8'(want.frame_end));
    if (m_axis_tuser[3] !== want.message_end)
      report_mismatch("message_end", 8'(m_axis_tuser[3]), 8'(want.message_end));
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      rx_phase        = wsfd_pkg::PH_HDR0;
      cur_opcode      = '0;
      cur_fin         = 1'b0;
      ext_bytes_left  = '0;
      bytes_remaining = '0;
      awaited_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_output();
    end
    outstanding = awaited_results.size();
  end

endmodule

>>> verif/tb_websocket_frame_deframer_core.sv
// Testbench top for the WebSocket frame deframer: stimulus, idling and the final verdict.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_core;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] payload_byte
  logic       m_axis_tlast;           // frame_end
  logic [3:0] m_axis_tuser;           // [0] has_payload, [2:1] frame_kind, [3] message_end

  int fails;
  int outstanding;
  int src_idle_pct  = 32;
  int sink_idle_pct = 51;
  int random_bytes  = 0;
  int cycle_count   = 0;

  websocket_frame_deframer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  websocket_frame_deframer_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fails         (fails),
    .outstanding   (outstanding)
  );

  always #10 clk = ~clk;

  // Receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte, with a random gap first, and hold it until it is accepted.
  // Called and returning at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Stop sending until every predicted result has left the block.
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // One frame, mostly well formed, with random content.
  task automatic send_random_frame();
    logic [3:0]  op;
    logic [6:0]  len7;
    logic [63:0] len64;
    int unsigned plen;
    int unsigned pick;
    int unsigned form;
    int          n_ext;

    pick = $urandom_range(99);
    if (pick < 35)      op = wsfd_pkg::OP_TEXT;
    else if (pick < 55) op = wsfd_pkg::OP_CONT;
    else if (pick < 67) op = wsfd_pkg::OP_PING;
    else if (pick < 79) op = wsfd_pkg::OP_CLOSE;
    else                op = 4'($urandom);

    form = $urandom_range(99);
    if (form < 70) begin
      // Short form; now and then a long one up to 125, the largest short-form length.
      plen  = ($urandom_range(19) == 0) ? $urandom_range(125) : $urandom_range(12);
      len7  = 7'(plen);
      n_ext = 0;
    end else if (form < 87) begin
      // Sixteen-bit form, often with a value that would fit the short form.
      plen  = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(20);
      len7  = wsfd_pkg::LEN_EXT16;
      n_ext = 2;
    end else begin
      plen  = $urandom_range(20);
      len7  = wsfd_pkg::LEN_EXT64;
      n_ext = 8;
    end
    len64 = 64'(plen);

    send_byte({1'($urandom), 3'($urandom), op});
    send_byte({1'($urandom), len7});
    for (int i = n_ext - 1; i >= 0; i--) send_byte(len64[i*8 +: 8]);
    for (int unsigned i = 0; i < plen; i++) send_byte(8'($urandom));
    random_bytes += 2 + n_ext + plen;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty final text frame: the length byte itself ends the frame and the message.
    send_byte({1'b1, 3'b000, wsfd_pkg::OP_TEXT});
    send_byte({1'b0, 7'd0});
    // Ping with one payload byte of all ones.
    send_byte({1'b1, 3'b000, wsfd_pkg::OP_PING});
    send_byte({1'b0, 7'd1});
    send_byte(8'hff);
    // Close with the mask bit set, which is ignored, and an all-zero payload byte.
    send_byte({1'b1, 3'b000, wsfd_pkg::OP_CLOSE});
    send_byte({1'b1, 7'd1});
    send_byte(8'h00);
    // Continuation without FIN and with the reserved bits set.
    send_byte({1'b0, 3'b111, wsfd_pkg::OP_CONT});
    send_byte({1'b0, 7'd1});
    send_byte(8'ha5);
    // Sixteen-bit form carrying a zero length: ends on the last length byte.
    send_byte({1'b1, 3'b000, wsfd_pkg::OP_TEXT});
    send_byte({1'b0, wsfd_pkg::LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h00);
    // Sixty-four-bit form, masked, on an opcode outside the named kinds.
    send_byte({1'b1, 3'b000, 4'ha});
    send_byte({1'b1, wsfd_pkg::LEN_EXT64});
    for (int i = 0; i < 7; i++) send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h42);
    drain_outputs();

    // Random frames, receiver quieter than sender.
    while (random_bytes < 350) send_random_frame();
    drain_outputs();

    // The other way round.
    src_idle_pct  = 51;
    sink_idle_pct = 32;
    while (random_bytes < 700) send_random_frame();
    drain_outputs();

    // Full rate on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (random_bytes < 1050) send_random_frame();
    drain_outputs();

    repeat (8) @(negedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
